/* hdl/esa_pkg.sv */
// Shared widths, reset values, register indexes and control structs for the
// encoder speed averager. No dependencies.
`timescale 1ns / 1ps

package esa_pkg;

  // Field widths.
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned OVF_W   = 16;
  localparam int unsigned LINES_W = 14;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned SPD_W   = 16;

  // Datapath widths.
  localparam int unsigned CPR_W   = LINES_W + 2;       // 4 * lines
  localparam int unsigned K_W     = 20;                // rate * 10 < 2^20
  localparam int unsigned WRAP_W  = OVF_W + CPR_W;     // overflows * counts per rev
  localparam int unsigned D0_W    = CNT_W + 1;         // signed count difference
  localparam int unsigned DELTA_W = WRAP_W + 2;        // signed full delta
  localparam int unsigned MAG_W   = DELTA_W - 1;       // magnitude of delta
  localparam int unsigned PROD_W  = MAG_W + K_W;       // |delta| * rate * 10
  localparam int unsigned DIVD_W  = PROD_W + 1;        // even dividend width
  localparam int unsigned DIV_STEPS_SPEED = DIVD_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS_SPEED + 1);

  // Configuration.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LINES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;
  localparam logic [LINES_W-1:0] LINES_RST = 14'd400;
  localparam logic [RATE_W-1:0]  RATE_RST  = 16'd1000;

  localparam int unsigned RING_DEPTH_DEF = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_wrap;
    logic mag;
    logic mul_scale;
    logic div_speed;
    logic ring;
    logic avg;
    logic out_load;
  } esa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } esa_sts_t;

endpackage

/* hdl/esa_if.sv */
// Valid/ready channel interfaces for the encoder speed averager: input ticks,
// results and configuration writes. Depends on esa_pkg.
`timescale 1ns / 1ps

interface esa_in_if import esa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   counter_value;
  logic [OVF_W-1:0]   overflow_count;
  logic               count_down;
  logic               clear_history;

  modport source (output valid, counter_value, overflow_count, count_down, clear_history,
                  input ready);
  modport sink   (input valid, counter_value, overflow_count, count_down, clear_history,
                  output ready);
endinterface

interface esa_out_if import esa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SPD_W-1:0]  instant_speed;
  logic signed [SPD_W-1:0]  average_speed;

  modport source (output valid, instant_speed, average_speed, input ready);
  modport sink   (input valid, instant_speed, average_speed, output ready);
endinterface

interface esa_cfg_if import esa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/esa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module esa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/esa_div.sv */
// Restoring divider that retires two quotient bits per cycle and keeps the
// low quotient bits. Depends on esa_pkg for the counter width.
`timescale 1ns / 1ps

module esa_div import esa_pkg::*; #(
  parameter int unsigned DVD_W = DIVD_W,
  parameter int unsigned DVS_W = CPR_W,
  parameter int unsigned Q_W   = SPD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVD_W-1:0]     dividend_i,
  input  logic [DVS_W-1:0]     divisor_i,
  input  logic [DIV_CNT_W-1:0] steps_i,
  output logic                 done_o,
  output logic [Q_W-1:0]       quotient_o
);

  logic [DVD_W-1:0]     dvd_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DVS_W-1:0]     rem_q;
  logic [Q_W-1:0]       quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;

  logic [DVS_W:0]   trial1, trial2, dvs_ext;
  logic             ge1, ge2;
  logic [DVS_W-1:0] rem1, rem2;

  // Two dependent shift-subtract steps; the partial remainder always stays
  // below the divisor, so it fits the divisor width.
  always_comb begin
    dvs_ext = {1'b0, dvs_q};
    trial1  = {rem_q, dvd_q[DVD_W-1]};
    ge1     = (trial1 >= dvs_ext);
    rem1    = ge1 ? DVS_W'(trial1 - dvs_ext) : DVS_W'(trial1);
    trial2  = {rem1, dvd_q[DVD_W-2]};
    ge2     = (trial2 >= dvs_ext);
    rem2    = ge2 ? DVS_W'(trial2 - dvs_ext) : DVS_W'(trial2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 2;
      rem_q <= rem2;
      quo_q <= {quo_q[Q_W-3:0], ge1, ge2};
    end
  end

  // The last step is taken at the edge that ends this cycle.
  assign done_o     = busy_q && (cnt_q == DIV_CNT_W'(1));
  assign quotient_o = quo_q;

endmodule

/* hdl/esa_dp.sv */
// Datapath of the encoder speed averager: configuration registers, delta and
// scaling arithmetic, speed ring with its running sum, and the output register.
// Depends on esa_pkg, esa_ram and esa_div.
`timescale 1ns / 1ps

module esa_dp import esa_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  esa_cmd_t               cmd_i,
  output esa_sts_t               sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [CNT_W-1:0]       counter_value_i,
  input  logic [OVF_W-1:0]       overflow_count_i,
  input  logic                   count_down_i,
  input  logic                   clear_history_i,
  output logic signed [SPD_W-1:0] instant_speed_o,
  output logic signed [SPD_W-1:0] average_speed_o
);

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SW = SPD_W + $clog2(RING_DEPTH);
  // The ring mean is taken by a reciprocal multiplication that is exact for
  // every sum magnitude below 2^SW.
  localparam int unsigned AVG_SH = SW + $clog2(RING_DEPTH);
  localparam int unsigned RCP_W  = SW + 1;
  localparam int unsigned AVG_PW = SW + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  // Configuration and state that survive between ticks.
  logic [LINES_W-1:0]     lines_q;
  logic [RATE_W-1:0]      rate_q;
  logic [CNT_W-1:0]       prev_q;
  logic                   first_q;
  logic [RING_DEPTH-1:0]  vld_q;
  logic [IW-1:0]          idx_q;
  logic signed [SW-1:0]   sum_q;

  // Per-tick working registers.
  logic [D0_W-1:0]    d0_q;
  logic [OVF_W-1:0]   ovf_q;
  logic               down_q;
  logic               zero_q;
  logic [WRAP_W-1:0]  wrap_q;
  logic [K_W-1:0]     k_q;
  logic               neg_q;
  logic [MAG_W-1:0]   mag_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SPD_W-1:0]   speed_q;
  logic [SPD_W-1:0]   avg_mag_q;
  logic [SPD_W-1:0]   out_speed_q;
  logic [SPD_W-1:0]   out_avg_q;

  logic [CPR_W-1:0]   cpr;
  logic [DELTA_W-1:0] delta;
  logic [SPD_W-1:0]   quo;
  logic [SPD_W-1:0]   speed_d;
  logic [SPD_W-1:0]   old_speed;
  logic [SPD_W-1:0]   ram_rdata;
  logic [SW-1:0]      sum_mag;
  logic [AVG_PW-1:0]  avg_prod;
  logic               div_done;

  assign cpr = {lines_q, 2'b00};

  always_comb begin
    if (down_q) begin
      delta = DELTA_W'($signed(d0_q)) - DELTA_W'(wrap_q);
    end else begin
      delta = DELTA_W'($signed(d0_q)) + DELTA_W'(wrap_q);
    end
  end

  // Speed is zero on the first measurement, on a tick that clears the history and when there are no lines.
  always_comb begin
    if (zero_q) begin
      speed_d = '0;
    end else if (neg_q) begin
      speed_d = SPD_W'(-quo);
    end else begin
      speed_d = quo;
    end
  end

  assign old_speed = vld_q[idx_q] ? ram_rdata : '0;
  assign sum_mag   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign avg_prod  = AVG_PW'(sum_mag) * AVG_PW'(AVG_RCP);

  // The divider serves the speed, dividing by the counts per revolution.
  esa_div #(
    .DVD_W (DIVD_W),
    .DVS_W (CPR_W),
    .Q_W   (SPD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_speed),
    .dividend_i ({1'b0, prod_q}),
    .divisor_i  (cpr),
    .steps_i    (DIV_CNT_W'(DIV_STEPS_SPEED)),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  esa_ram #(
    .WIDTH (SPD_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ring),
    .waddr_i (idx_q),
    .wdata_i (speed_d),
    .re_i    (cmd_i.load),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= LINES_RST;
      rate_q  <= RATE_RST;
      prev_q  <= '0;
      first_q <= 1'b1;
      vld_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LINES: lines_q <= cfg_data_i[LINES_W-1:0];
          REG_RATE:  rate_q  <= cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        prev_q  <= counter_value_i;
        first_q <= 1'b0;
        if (clear_history_i) begin
          vld_q <= '0;
          sum_q <= '0;
        end
      end
      if (cmd_i.ring) begin
        vld_q[idx_q] <= 1'b1;
        sum_q <= sum_q - SW'($signed(old_speed)) + SW'($signed(speed_d));
        if (idx_q == IW'(RING_DEPTH - 1)) begin
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d0_q   <= {1'b0, counter_value_i} - {1'b0, prev_q};
      ovf_q  <= overflow_count_i;
      down_q <= count_down_i;
      zero_q <= clear_history_i | first_q | (lines_q == '0);
    end
    if (cmd_i.mul_wrap) begin
      wrap_q <= WRAP_W'(ovf_q) * WRAP_W'(cpr);
      k_q    <= K_W'({rate_q, 3'b000}) + K_W'({rate_q, 1'b0});
    end
    if (cmd_i.mag) begin
      neg_q <= delta[DELTA_W-1];
      mag_q <= delta[DELTA_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
    end
    if (cmd_i.mul_scale) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(k_q);
    end
    if (cmd_i.ring) begin
      speed_q <= speed_d;
    end
    if (cmd_i.avg) begin
      avg_mag_q <= avg_prod[AVG_SH +: SPD_W];
    end
    if (cmd_i.out_load) begin
      out_speed_q <= speed_q;
      out_avg_q   <= sum_q[SW-1] ? SPD_W'(-avg_mag_q) : avg_mag_q;
    end
  end

  assign sts_o.div_done  = div_done;
  assign instant_speed_o = $signed(out_speed_q);
  assign average_speed_o = $signed(out_avg_q);

endmodule

/* hdl/esa_ctrl.sv */
// Controller of the encoder speed averager: sequences one tick through the
// datapath and owns the input and output handshakes. Depends on esa_pkg.
`timescale 1ns / 1ps

module esa_ctrl import esa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  esa_sts_t sts_i,
  output esa_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_MAG   = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_SDIV0 = 4'd4;
  localparam logic [3:0] S_SDIV  = 4'd5;
  localparam logic [3:0] S_RING  = 4'd6;
  localparam logic [3:0] S_AVG   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd_o.mul_wrap = 1'b1;
        state_d        = S_MAG;
      end
      S_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.mul_scale = 1'b1;
        state_d         = S_SDIV0;
      end
      S_SDIV0: begin
        cmd_o.div_speed = 1'b1;
        state_d         = S_SDIV;
      end
      S_SDIV: begin
        if (sts_i.div_done) begin
          state_d = S_RING;
        end
      end
      S_RING: begin
        cmd_o.ring = 1'b1;
        state_d    = S_AVG;
      end
      S_AVG: begin
        cmd_o.avg = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/encoder_speed_averager_core.sv */
// Top level of the encoder speed averager: controller, datapath and channel
// wiring. Depends on esa_pkg, esa_if, esa_ctrl and esa_dp.
`timescale 1ns / 1ps

// The block turns one encoder sample per speed tick into an instantaneous
// speed in 0.1 rev/s and the mean of the last RING_DEPTH speeds.
// Input channel: one transaction per tick, carrying the settled counter value,
// the overflows since the previous tick, the count direction and a request to
// clear the speed history before this tick is used.
// Output channel: one transaction per tick with both speeds.
// Configuration channel: always ready; index 0 writes the encoder lines per
// revolution, index 1 the tick rate in hertz; other indexes are ignored.
// Write it only while no tick is in flight.
// From an accepted input transaction to a valid result, a tick passes through
// the load, the wrap product, the magnitude, the scale product, the divider
// start, the two-bit-per-cycle speed divider, the ring update, the mean and
// the output load, in that order. One tick is in work at a time, so a new
// input transaction is taken in the cycle after the result is loaded.
// A finished result sits in an output register; a stalled receiver does not
// stop the next tick from being computed, only from being delivered.
// Reset restores the default configuration (400 lines, 1000 Hz), empties the
// history and marks the next tick as the first measurement, which reads 0.

module encoder_speed_averager_core import esa_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  esa_in_if.sink      in_i,
  esa_out_if.source   out_o,
  esa_cfg_if.sink     cfg_i
);

  esa_cmd_t cmd;
  esa_sts_t sts;
  logic     cfg_we;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  esa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esa_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .counter_value_i  (in_i.counter_value),
    .overflow_count_i (in_i.overflow_count),
    .count_down_i     (in_i.count_down),
    .clear_history_i  (in_i.clear_history),
    .instant_speed_o  (out_o.instant_speed),
    .average_speed_o  (out_o.average_speed)
  );

endmodule
